// ===== rtl/day_table_window_average_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the day table window average unit
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DAY_TABLE_WINDOW_AVERAGE_UNIT_DEFINES_SVH
`define DAY_TABLE_WINDOW_AVERAGE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define DTWA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define DTWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DTWA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define DTWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/dtwa_pkg.sv =====
// ----------------------------------------------------------------------------
// dtwa_pkg
// Shared constants, codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package dtwa_pkg;

  localparam int TABLE_DEPTH = 16384;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int DAY_W   = 17;
  localparam int VAL_W   = 16;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = DAY_W + 1;

  localparam int HALF_SPAN = 40;
  localparam int SPAN_BACK = 80;
  localparam int SPAN_LEN  = 81;

  localparam int WIN_W  = $clog2(TABLE_DEPTH + HALF_SPAN);
  localparam int SUM_W  = $clog2(SPAN_LEN * ((1 << VAL_W) - 1) + 1);

  // floor(x / 81) = (x * DIV_MULT) >> DIV_SHIFT, exact for x < 2**27
  localparam int DIV_SHIFT = 30;
  localparam int MULT_W    = 24;
  localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(13256072);
  localparam int PROD_W    = SUM_W + MULT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_AVG    = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNAVAIL = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic do_load;
    logic set_full;
    logic set_unavail;
    logic rd_single;
    logic win_init;
    logic rd_window;
    logic take_rdata;
    logic mul;
    logic take_quot;
    logic push;
  } dtwa_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              avail;
    logic              full;
    logic              win_last;
    logic              out_free;
  } dtwa_sts_t;

endpackage

`default_nettype wire

// ===== rtl/dtwa_if.sv =====
// ----------------------------------------------------------------------------
// dtwa channel interfaces
// Valid/ready channels for items, results and the configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtwa_in_if;
  logic                             valid;
  logic                             ready;
  logic [dtwa_pkg::KIND_W-1:0]      kind;
  logic signed [dtwa_pkg::DAY_W-1:0] day;
  logic [dtwa_pkg::VAL_W-1:0]       load_value;

  modport source(output valid, kind, day, load_value, input ready);
  modport sink(input valid, kind, day, load_value, output ready);
endinterface

interface dtwa_out_if;
  logic                        valid;
  logic                        ready;
  logic [dtwa_pkg::VAL_W-1:0]  value;
  logic [dtwa_pkg::STAT_W-1:0] status;

  modport source(output valid, value, status, input ready);
  modport sink(input valid, value, status, output ready);
endinterface

interface dtwa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic signed [dtwa_pkg::DAY_W-1:0] first_day;

  modport source(output valid, first_day, input ready);
  modport sink(input valid, first_day, output ready);
endinterface

`default_nettype wire

// ===== rtl/dtwa_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtwa_ctrl
// Sequencer: decodes each item and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtwa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dtwa_pkg::dtwa_sts_t sts,
  output dtwa_pkg::dtwa_cmd_t     cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_EXEC   = 9'b000000100,
    S_LOOK   = 9'b000001000,
    S_SUM    = 9'b000010000,
    S_TAIL   = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_QUOT   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (sts.kind)
          dtwa_pkg::KIND_LOAD: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.do_load = 1'b1;
            end
          end
          dtwa_pkg::KIND_LOOKUP: begin
            if (sts.avail) begin
              cmd.rd_single = 1'b1;
              state_nxt     = S_LOOK;
            end else begin
              cmd.set_unavail = 1'b1;
            end
          end
          dtwa_pkg::KIND_AVG: begin
            if (sts.avail) begin
              cmd.win_init = 1'b1;
              state_nxt    = S_SUM;
            end else begin
              cmd.set_unavail = 1'b1;
            end
          end
          default: begin
            cmd.set_unavail = 1'b1;
          end
        endcase
      end
      S_LOOK: begin
        cmd.take_rdata = 1'b1;
        state_nxt      = S_DONE;
      end
      S_SUM: begin
        // one table read per cycle, accumulated in the cycle after
        cmd.rd_window = 1'b1;
        if (sts.win_last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_QUOT;
      end
      S_QUOT: begin
        cmd.take_quot = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/dtwa_dp.sv =====
// ----------------------------------------------------------------------------
// dtwa_dp
// Datapath: day table memory, entry count, window accumulator,
// divide-by-81 multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtwa_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire dtwa_pkg::dtwa_cmd_t                 cmd,
  output dtwa_pkg::dtwa_sts_t                      sts,
  input  wire logic [dtwa_pkg::KIND_W-1:0]         in_kind,
  input  wire logic signed [dtwa_pkg::DAY_W-1:0]   in_day,
  input  wire logic [dtwa_pkg::VAL_W-1:0]          in_load_value,
  input  wire logic                                cfg_we,
  input  wire logic signed [dtwa_pkg::DAY_W-1:0]   cfg_first_day,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [dtwa_pkg::VAL_W-1:0]               out_value,
  output logic [dtwa_pkg::STAT_W-1:0]              out_status
);

  logic [dtwa_pkg::VAL_W-1:0]       mem [dtwa_pkg::TABLE_DEPTH];

  logic [dtwa_pkg::KIND_W-1:0]      kind_r;
  logic [dtwa_pkg::DAY_W-1:0]       day_r;
  logic [dtwa_pkg::VAL_W-1:0]       load_value_r;
  logic [dtwa_pkg::DAY_W-1:0]       first_day_r;
  logic [dtwa_pkg::CNT_W-1:0]       count_r;
  logic [dtwa_pkg::ADDR_W-1:0]      idx_r;
  logic                             avail_r;
  logic [dtwa_pkg::ADDR_W-1:0]      addr_r;
  logic [dtwa_pkg::ADDR_W-1:0]      hi_r;
  logic [dtwa_pkg::VAL_W-1:0]       rdata_r;
  logic                             acc_pend_r;
  logic [dtwa_pkg::SUM_W-1:0]       sum_r;
  logic [dtwa_pkg::PROD_W-1:0]      prod_r;
  logic [dtwa_pkg::VAL_W-1:0]       result_r;
  logic [dtwa_pkg::STAT_W-1:0]      status_r;
  logic                             out_valid_r;
  logic [dtwa_pkg::VAL_W-1:0]       out_value_r;
  logic [dtwa_pkg::STAT_W-1:0]      out_status_r;

  logic [dtwa_pkg::IDX_W-1:0]       diff;
  logic                             avail_nxt;
  logic [dtwa_pkg::WIN_W-1:0]       win_top;
  logic [dtwa_pkg::WIN_W-1:0]       win_last_ent;
  logic [dtwa_pkg::WIN_W-1:0]       win_hi;
  logic [dtwa_pkg::WIN_W-1:0]       win_lo;
  logic [dtwa_pkg::ADDR_W-1:0]      rd_addr;

  // entry index of the query day; valid only when non-negative and loaded
  assign diff = {day_r[dtwa_pkg::DAY_W-1], day_r}
              - {first_day_r[dtwa_pkg::DAY_W-1], first_day_r};
  assign avail_nxt = !diff[dtwa_pkg::IDX_W-1]
                   && (diff < dtwa_pkg::IDX_W'(count_r));

  assign win_top      = dtwa_pkg::WIN_W'(idx_r) + dtwa_pkg::WIN_W'(dtwa_pkg::HALF_SPAN);
  assign win_last_ent = dtwa_pkg::WIN_W'(count_r) - dtwa_pkg::WIN_W'(1);
  assign win_hi       = (win_top > win_last_ent) ? win_last_ent : win_top;
  assign win_lo       = (win_hi >= dtwa_pkg::WIN_W'(dtwa_pkg::SPAN_BACK))
                      ? (win_hi - dtwa_pkg::WIN_W'(dtwa_pkg::SPAN_BACK))
                      : '0;

  assign rd_addr = cmd.rd_window ? addr_r : idx_r;

  // single-port table: write on load, read on lookup or window step
  always_ff @(posedge clk) begin
    if (cmd.do_load) begin
      mem[count_r[dtwa_pkg::ADDR_W-1:0]] <= load_value_r;
    end else if (cmd.rd_single || cmd.rd_window) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      first_day_r <= '0;
      acc_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        first_day_r <= cfg_first_day;
      end
      if (cmd.do_load) begin
        count_r <= count_r + dtwa_pkg::CNT_W'(1);
      end
      acc_pend_r <= cmd.rd_window;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r       <= in_kind;
      day_r        <= in_day;
      load_value_r <= in_load_value;
    end
    if (cmd.decode) begin
      idx_r   <= diff[dtwa_pkg::ADDR_W-1:0];
      avail_r <= avail_nxt;
    end
    if (cmd.win_init) begin
      addr_r <= win_lo[dtwa_pkg::ADDR_W-1:0];
      hi_r   <= win_hi[dtwa_pkg::ADDR_W-1:0];
      sum_r  <= '0;
    end else begin
      if (cmd.rd_window) begin
        addr_r <= addr_r + dtwa_pkg::ADDR_W'(1);
      end
      if (acc_pend_r) begin
        sum_r <= sum_r + dtwa_pkg::SUM_W'(rdata_r);
      end
    end
    if (cmd.mul) begin
      prod_r <= dtwa_pkg::PROD_W'(sum_r) * dtwa_pkg::PROD_W'(dtwa_pkg::DIV_MULT);
    end
    if (cmd.do_load) begin
      result_r <= '0;
      status_r <= dtwa_pkg::ST_OK;
    end
    if (cmd.set_full) begin
      result_r <= '0;
      status_r <= dtwa_pkg::ST_FULL;
    end
    if (cmd.set_unavail) begin
      result_r <= '0;
      status_r <= dtwa_pkg::ST_UNAVAIL;
    end
    if (cmd.take_rdata) begin
      result_r <= rdata_r;
      status_r <= dtwa_pkg::ST_OK;
    end
    if (cmd.take_quot) begin
      result_r <= prod_r[dtwa_pkg::DIV_SHIFT +: dtwa_pkg::VAL_W];
      status_r <= dtwa_pkg::ST_OK;
    end
    if (cmd.push) begin
      out_value_r  <= result_r;
      out_status_r <= status_r;
    end
  end

  always_comb begin
    sts          = '0;
    sts.kind     = kind_r;
    sts.avail    = avail_r;
    sts.full     = (count_r == dtwa_pkg::CNT_W'(dtwa_pkg::TABLE_DEPTH));
    sts.win_last = (addr_r == hi_r);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/day_table_window_average_unit.sv =====
// ----------------------------------------------------------------------------
// day_table_window_average_unit
// Daily value table with lookup and 81-day window average.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch  writes first_day, the day number of table entry 0; always ready.
//           Write it only while the unit is idle.
//   in_ch   takes one item per beat: kind 0 appends load_value to the table,
//           kind 1 looks up the value for day, kind 2 averages the window
//           around day (sum of up to 81 entries, divided by 81, truncated).
//   out_ch  gives exactly one beat per item: value and status
//           (0 ok, 1 day not available, 2 table full on load).
//   Items are handled one at a time. A load, an unavailable day or an
//   unused kind is decoded and executed; a lookup adds a table read; a
//   window average reads its entries in turn, then multiplies the sum by
//   a scaled reciprocal of 81 and takes the quotient. The window average
//   reads the single-port table memory one entry per cycle. The next item
//   can be taken in the cycle after the result is placed in the output
//   register, so a stalled receiver holds at most one finished result
//   while the next item is worked on.
//   Reset empties the table (entry count 0) and clears first_day; the
//   table memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "day_table_window_average_unit_defines.svh"

module day_table_window_average_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dtwa_cfg_if.sink    cfg_ch,
  dtwa_in_if.sink     in_ch,
  dtwa_out_if.source  out_ch
);

  dtwa_pkg::dtwa_cmd_t cmd;
  dtwa_pkg::dtwa_sts_t sts;
  logic                in_ready;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  dtwa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtwa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_ch.kind),
    .in_day        (in_ch.day),
    .in_load_value (in_ch.load_value),
    .cfg_we        (cfg_ch.valid),
    .cfg_first_day (cfg_ch.first_day),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_value     (out_ch.value),
    .out_status    (out_ch.status)
  );

  `DTWA_ASSERT_SAME(a_push_when_free, clk, rst_n, cmd.push, sts.out_free)
  `DTWA_ASSERT_SAME(a_no_load_when_full, clk, rst_n, cmd.do_load, !sts.full)
  `DTWA_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_ch.valid && in_ready, !in_ready)

endmodule

`default_nettype wire

// ===== dv/tb_day_table_window_average_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_day_table_window_average_unit
// Drives load, lookup and window average items through the unit under random
// source gaps and sink stalls, predicts every result from a local copy of the
// day table, and checks each result beat in order. first_day moves between
// phases, and one phase puts the last loaded entry on the top day.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_day_table_window_average_unit;
  import dtwa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int DAY_MIN        = -(1 << (DAY_W - 1));
  localparam int DAY_MAX        = (1 << (DAY_W - 1)) - 1;
  localparam int QUIET_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 120;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_BEAT  = 420;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DAY_W-1:0]  day;
    logic [VAL_W-1:0]         load_value;
  } query_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_t          status;
  } result_t;

  logic clk;
  logic rst_n;

  dtwa_cfg_if cfg_ch();
  dtwa_in_if  in_ch();
  dtwa_out_if out_ch();

  day_table_window_average_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted state of the unit
  logic [VAL_W-1:0] day_store [TABLE_DEPTH];
  int               store_count;
  int               first_day_reg;

  // generator view of the same state, ahead of the unit
  int gen_count;
  int gen_first;

  query_t  queued_queries [$];
  result_t awaited_results [$];

  int  fail_count;
  int  in_beats;
  int  quiet_cycles;
  bit  in_taken;
  bit  idle_on;
  int  gap_left;
  int  stall_left;
  int  hold_left;
  bit  hold_done;

  function automatic void compute_day_result(input query_t q, output result_t r);
    int          idx;
    int          hi;
    int          lo;
    int unsigned sum;
    r.value  = '0;
    r.status = ST_UNAVAIL;
    idx = int'(q.day) - first_day_reg;
    if (q.kind == KIND_LOAD) begin
      if (store_count < TABLE_DEPTH) begin
        day_store[store_count] = q.load_value;
        store_count++;
        r.status = ST_OK;
      end else begin
        r.status = ST_FULL;
      end
    end else if ((q.kind == KIND_LOOKUP || q.kind == KIND_AVG) &&
                 idx >= 0 && idx < store_count) begin
      r.status = ST_OK;
      if (q.kind == KIND_LOOKUP) begin
        r.value = day_store[idx];
      end else begin
        hi  = (idx + HALF_SPAN > store_count - 1) ? store_count - 1 : idx + HALF_SPAN;
        lo  = (hi >= SPAN_BACK) ? hi - SPAN_BACK : 0;
        sum = 0;
        for (int i = lo; i <= hi; i++) sum += day_store[i];
        r.value = VAL_W'(sum / SPAN_LEN);
      end
    end
  endfunction

  task automatic add_query(input logic [KIND_W-1:0] kind, input int day,
                           input logic [VAL_W-1:0] load_value);
    query_t q;
    q.kind       = kind;
    q.day        = DAY_W'(day);
    q.load_value = load_value;
    queued_queries.push_back(q);
    if (kind == KIND_LOAD && gen_count < TABLE_DEPTH) gen_count++;
  endtask

  // mostly days inside the loaded range, biased toward both ends of it
  function automatic int pick_day();
    int sel;
    int span;
    int d;
    sel  = $urandom_range(0, 99);
    span = (gen_count > 46) ? 45 : gen_count - 1;
    if (gen_count == 0 || sel < 10)
      d = DAY_MIN + int'($urandom_range(0, DAY_MAX - DAY_MIN));
    else if (sel < 22)
      d = $urandom_range(0, 1) ? gen_first - 1 - int'($urandom_range(0, 3))
                               : gen_first + gen_count + int'($urandom_range(0, 3));
    else if (sel < 34)
      d = gen_first + int'($urandom_range(0, span));
    else if (sel < 46)
      d = gen_first + gen_count - 1 - int'($urandom_range(0, span));
    else
      d = gen_first + int'($urandom_range(0, gen_count - 1));
    if (d < DAY_MIN || d > DAY_MAX)
      d = DAY_MIN + int'($urandom_range(0, DAY_MAX - DAY_MIN));
    return d;
  endfunction

  task automatic add_random_queries(input int n, input int load_pct);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < load_pct)
        add_query(KIND_LOAD, pick_day(), VAL_W'($urandom));
      else if (sel < 98 - (98 - load_pct) / 2)
        add_query(KIND_LOOKUP, pick_day(), VAL_W'($urandom));
      else if (sel < 98)
        add_query(KIND_AVG, pick_day(), VAL_W'($urandom));
      else
        add_query(KIND_UNUSED, pick_day(), VAL_W'($urandom));
    end
  endtask

  // wait until every queued item went in and every result came out
  task automatic wait_idle();
    while (queued_queries.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_day(input int fd);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.first_day <= DAY_W'(fd);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    gen_first = fd;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // source side: present queued items, with random gaps between beats
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (queued_queries.size() != 0) begin
        query_t q;
        q = queued_queries.pop_front();
        in_ch.kind       <= q.kind;
        in_ch.day        <= q.day;
        in_ch.load_value <= q.load_value;
        in_ch.valid      <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 9);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // sink side: random stalls, plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && in_beats >= HOLD_OFF_BEAT) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin : watch_beats
    query_t  q;
    result_t want;
    if (rst_n) begin
      in_taken = in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) first_day_reg = int'(cfg_ch.first_day);
      if (in_taken) begin
        q.kind       = in_ch.kind;
        q.day        = in_ch.day;
        q.load_value = in_ch.load_value;
        compute_day_result(q, want);
        awaited_results.push_back(want);
        in_beats++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat: value %0d status %0d", $time,
                   out_ch.value, out_ch.status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.value !== want.value || out_ch.status !== want.status) begin
            $display("%0t: result mismatch: expected value %0d status %0d, got value %0d status %0d",
                     $time, want.value, want.status, out_ch.value, out_ch.status);
            fail_count++;
          end
        end
      end
      if (in_taken || (out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_day_table_window_average_unit NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int fd;
    rst_n            = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.first_day = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_LOAD;
    in_ch.day        = '0;
    in_ch.load_value = '0;
    out_ch.ready     = 1'b0;
    store_count   = 0;
    first_day_reg = 0;
    gen_count     = 0;
    gen_first     = 0;
    fail_count    = 0;
    in_beats      = 0;
    quiet_cycles  = 0;
    in_taken      = 1'b0;
    idle_on       = 1'b1;
    gap_left      = 0;
    stall_left    = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // empty table, unused kind, a few loads mostly at the value extremes, then lookups and averages
    add_query(KIND_LOOKUP, 0, 16'd0);
    add_query(KIND_AVG, 0, 16'd0);
    add_query(KIND_UNUSED, 0, 16'hFFFF);
    add_query(KIND_LOAD, 0, 16'd0);
    add_query(KIND_LOAD, 0, 16'hFFFF);
    add_query(KIND_LOAD, DAY_MIN, 16'hFFFF);
    add_query(KIND_LOAD, DAY_MAX, 16'd1);
    add_query(KIND_LOAD, 0, 16'd12345);
    add_query(KIND_LOOKUP, 0, 16'd0);
    add_query(KIND_LOOKUP, 1, 16'd0);
    add_query(KIND_LOOKUP, 4, 16'd0);
    add_query(KIND_LOOKUP, 5, 16'd0);
    add_query(KIND_LOOKUP, -1, 16'd0);
    add_query(KIND_LOOKUP, DAY_MIN, 16'd0);
    add_query(KIND_LOOKUP, DAY_MAX, 16'd0);
    add_query(KIND_AVG, 0, 16'd0);
    add_query(KIND_AVG, 4, 16'd0);
    add_query(KIND_AVG, 5, 16'd0);
    add_query(KIND_AVG, -1, 16'd0);
    add_query(KIND_UNUSED, 2, 16'd7);
    add_query(KIND_LOOKUP, 4, 16'd0);
    wait_idle();

    write_first_day(DAY_MIN);
    add_random_queries(170, 40);
    wait_idle();

    write_first_day(DAY_MAX);
    add_random_queries(130, 40);
    wait_idle();

    write_first_day(DAY_MIN + int'($urandom_range(0, DAY_MAX - DAY_MIN)));
    add_random_queries(170, 40);
    wait_idle();

    write_first_day(int'($urandom_range(0, 4000)) - 2000);
    add_random_queries(170, 40);
    wait_idle();

    // put the last loaded entry on the top day, then probe around it
    fd = DAY_MAX - gen_count + 1;
    write_first_day(fd);
    add_query(KIND_LOOKUP, DAY_MAX, 16'd0);
    add_query(KIND_AVG, DAY_MAX, 16'd0);
    add_query(KIND_AVG, DAY_MAX - HALF_SPAN, 16'd0);
    add_query(KIND_AVG, DAY_MAX - HALF_SPAN - 1, 16'd0);
    add_query(KIND_AVG, fd, 16'd0);
    add_query(KIND_LOOKUP, fd - 1, 16'd0);
    wait_idle();

    // last part without gaps or stalls
    idle_on = 1'b0;
    write_first_day(DAY_MAX - TABLE_DEPTH + 1);
    add_random_queries(280, 20);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("tb_day_table_window_average_unit OK");
    end else begin
      $display("tb_day_table_window_average_unit NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
